### hw/rtl/tcfl_pkg.sv
package tcfl_pkg;

   localparam int SETS      = 64;
   localparam int WAYS      = 4;
   localparam int LINE_UOPS = 16;

   localparam int LINES  = SETS * WAYS;
   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOT_W = (LINE_UOPS > 1) ? $clog2(LINE_UOPS) : 1;
   localparam int AMEM_W = (LINES * LINE_UOPS > 1) ? $clog2(LINES * LINE_UOPS) : 1;

   localparam int WORD_W = 32;
   localparam int MASK_W = 16;
   localparam int CNT_W  = 5;
   localparam int CFG_W  = 5;
   localparam int UOPS_W = 6;
   localparam int SIZE_W = 4;
   localparam int BIT_W  = 4;

   typedef enum logic [0:0] {
      CSR_MAX_LINE_UOPS     = 1'b0,
      CSR_MAX_LINE_BRANCHES = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      FUNC_RECORD = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef struct packed {
      logic [WORD_W-1:0] tag;
      logic [MASK_W-1:0] mask;
      logic [MASK_W-1:0] taken;
      logic [CNT_W-1:0]  bcount;
      logic [WORD_W-1:0] target;
      logic [WORD_W-1:0] fall;
      logic [CNT_W-1:0]  icount;
      logic              ends;
      logic [WAY_W-1:0]  age;
   } meta_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_APPEND,
      ST_BR_CHK,
      ST_C_ADJ,
      ST_C_SRD,
      ST_C_SCMP,
      ST_C_ARD,
      ST_C_AWR,
      ST_C_WMETA,
      ST_C_WADDR,
      ST_C_DONE,
      ST_L_RD,
      ST_L_CMP,
      ST_L_HIT,
      ST_MISS,
      ST_S_RD,
      ST_S_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic append;
      logic adjust;
      logic clear_build;
      logic way_clr;
      logic way_inc;
      logic idx_clr;
      logic idx_inc;
      logic meta_rd_commit;
      logic meta_rd_lookup;
      logic age_wr;
      logic pick_set;
      logic meta_wr;
      logic addr_wr;
      logic hit_latch;
      logic addr_rd;
      logic out_miss;
      logic out_hit0;
      logic out_stream;
   } cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic rec_skip;
      logic overflow;
      logic too_big;
      logic br_close;
      logic tag_zero;
      logic search_take;
      logic last_way;
      logic lookup_hit;
      logic n_zero;
      logic last_idx_wr;
      logic last_idx_rd;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/trace_cache_fill_and_lookup_unit.sv
// Trace cache with fill unit: 64 sets by 4 ways of trace lines, up to 16 instruction
// addresses each. A record word (func 0) appends to the trace being built; when it closes
// a trace the commit searches the set one way at a time, lets the age counters pick a
// victim when no way can be taken, then writes the line and each stored address in turn,
// since the line array and the address array each have a single port. A lookup word
// (func 1) probes the set one way at a time, then gives a miss word or streams the hit's
// result words from the address array, each held while the output is stalled. Line valid
// bits clear at reset, so the block is ready right after reset. One word is processed
// at a time; the result register lets a new word be accepted while the last result waits.
module trace_cache_fill_and_lookup_unit
   import tcfl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [WORD_W-1:0] req_fetch_addr,
   input  logic              req_is_head,
   input  logic [UOPS_W-1:0] req_inst_uops,
   input  logic [SIZE_W-1:0] req_inst_size,
   input  logic              req_is_branch,
   input  logic [WORD_W-1:0] req_actual_next,
   input  logic [WORD_W-1:0] req_branch_target,
   input  logic [MASK_W-1:0] req_pred_bits,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic [WORD_W-1:0] rsp_inst_addr,
   output logic [CNT_W-1:0]  rsp_inst_count,
   output logic [WORD_W-1:0] rsp_next_fetch,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tcfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcfl_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_fetch_addr    (req_fetch_addr),
      .req_is_head       (req_is_head),
      .req_inst_uops     (req_inst_uops),
      .req_inst_size     (req_inst_size),
      .req_is_branch     (req_is_branch),
      .req_actual_next   (req_actual_next),
      .req_branch_target (req_branch_target),
      .req_pred_bits     (req_pred_bits),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_inst_addr     (rsp_inst_addr),
      .rsp_inst_count    (rsp_inst_count),
      .rsp_next_fetch    (rsp_next_fetch),
      .rsp_last          (rsp_last)
   );

endmodule

### hw/rtl/tcfl_ctrl.sv
module tcfl_ctrl
   import tcfl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      ret_append_ff, ret_append_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_append_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_append_ff <= ret_append_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      ret_append_in = ret_append_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_lookup) begin
               cmd.way_clr = 1'b1;
               state_in    = ST_L_RD;
            end else if (status.rec_skip) begin
               state_in = ST_IDLE;
            end else if (status.overflow) begin
               ret_append_in = 1'b1;
               state_in      = ST_C_ADJ;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (status.too_big) begin
               state_in = ST_IDLE;
            end else begin
               cmd.append = 1'b1;
               state_in   = ST_BR_CHK;
            end
         end
         ST_BR_CHK: begin
            if (status.br_close) begin
               ret_append_in = 1'b0;
               state_in      = ST_C_ADJ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_C_ADJ: begin
            if (status.tag_zero) begin
               cmd.clear_build = 1'b1;
               state_in        = ret_append_ff ? ST_APPEND : ST_IDLE;
            end else begin
               cmd.adjust  = 1'b1;
               cmd.way_clr = 1'b1;
               state_in    = ST_C_SRD;
            end
         end
         ST_C_SRD: begin
            cmd.meta_rd_commit = 1'b1;
            state_in           = ST_C_SCMP;
         end
         ST_C_SCMP: begin
            if (status.search_take) begin
               cmd.pick_set = 1'b1;
               state_in     = ST_C_WMETA;
            end else if (status.last_way) begin
               cmd.way_clr = 1'b1;
               state_in    = ST_C_ARD;
            end else begin
               cmd.way_inc = 1'b1;
               state_in    = ST_C_SRD;
            end
         end
         ST_C_ARD: begin
            cmd.meta_rd_commit = 1'b1;
            state_in           = ST_C_AWR;
         end
         ST_C_AWR: begin
            cmd.age_wr = 1'b1;
            if (status.last_way) begin
               state_in = ST_C_WMETA;
            end else begin
               cmd.way_inc = 1'b1;
               state_in    = ST_C_ARD;
            end
         end
         ST_C_WMETA: begin
            cmd.meta_wr = 1'b1;
            cmd.idx_clr = 1'b1;
            state_in    = ST_C_WADDR;
         end
         ST_C_WADDR: begin
            cmd.addr_wr = 1'b1;
            if (status.last_idx_wr) begin
               state_in = ST_C_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_C_DONE: begin
            cmd.clear_build = 1'b1;
            state_in        = ret_append_ff ? ST_APPEND : ST_IDLE;
         end
         ST_L_RD: begin
            cmd.meta_rd_lookup = 1'b1;
            state_in           = ST_L_CMP;
         end
         ST_L_CMP: begin
            if (status.lookup_hit) begin
               cmd.hit_latch = 1'b1;
               state_in      = ST_L_HIT;
            end else if (status.last_way) begin
               state_in = ST_MISS;
            end else begin
               cmd.way_inc = 1'b1;
               state_in    = ST_L_RD;
            end
         end
         ST_L_HIT: begin
            if (status.n_zero) begin
               if (status.out_free) begin
                  cmd.out_hit0 = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_S_RD;
            end
         end
         ST_MISS: begin
            if (status.out_free) begin
               cmd.out_miss = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_S_RD: begin
            cmd.addr_rd = 1'b1;
            state_in    = ST_S_OUT;
         end
         ST_S_OUT: begin
            if (status.out_free) begin
               cmd.out_stream = 1'b1;
               if (status.last_idx_rd) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_S_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/tcfl_dp.sv
module tcfl_dp
   import tcfl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              req_func,
   input  logic [WORD_W-1:0] req_fetch_addr,
   input  logic              req_is_head,
   input  logic [UOPS_W-1:0] req_inst_uops,
   input  logic [SIZE_W-1:0] req_inst_size,
   input  logic              req_is_branch,
   input  logic [WORD_W-1:0] req_actual_next,
   input  logic [WORD_W-1:0] req_branch_target,
   input  logic [MASK_W-1:0] req_pred_bits,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic [WORD_W-1:0] rsp_inst_addr,
   output logic [CNT_W-1:0]  rsp_inst_count,
   output logic [WORD_W-1:0] rsp_next_fetch,
   output logic              rsp_last
);

   function automatic logic [LINE_W-1:0] line_of(input logic [WORD_W-1:0] a,
                                                 input logic [WAY_W-1:0] w);
      return LINE_W'((a % SETS) * WAYS + int'(w));
   endfunction

   logic [CFG_W-1:0]  max_uops_ff, max_br_ff;

   logic              q_func_ff;
   logic [WORD_W-1:0] q_addr_ff, q_next_ff, q_target_ff;
   logic              q_head_ff, q_branch_ff;
   logic [UOPS_W-1:0] q_uops_ff;
   logic [SIZE_W-1:0] q_size_ff;
   logic [MASK_W-1:0] q_pred_ff;

   logic [WORD_W-1:0] b_tag_ff, b_tag_in;
   logic [CNT_W-1:0]  b_uops_ff, b_uops_in;
   logic [CNT_W-1:0]  b_insts_ff, b_insts_in;
   logic [CNT_W-1:0]  b_br_ff, b_br_in;
   logic [MASK_W-1:0] b_mask_ff, b_mask_in;
   logic [MASK_W-1:0] b_taken_ff, b_taken_in;
   logic [WORD_W-1:0] b_target_ff, b_target_in;
   logic [WORD_W-1:0] b_fall_ff, b_fall_in;
   logic              b_ends_ff, b_ends_in;
   logic [WORD_W-1:0] b_addrs_ff [LINE_UOPS];

   meta_type          meta_mem [LINES];
   logic [WORD_W-1:0] addr_mem [LINES * LINE_UOPS];
   logic              valid_ff [LINES];

   meta_type          rd_meta_ff, eff, age_meta, new_meta;
   logic              rd_valid_ff;
   logic [WAY_W-1:0]  rd_way_ff;
   logic [WORD_W-1:0] rd_addr_ff;

   logic [WAY_W-1:0]  way_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [LINE_W-1:0] pick_line_ff;
   logic [WAY_W-1:0]  pick_age_ff;
   logic [CNT_W-1:0]  hit_n_ff;
   logic [WORD_W-1:0] hit_nf_ff;

   logic              rsp_valid_ff, rsp_hit_ff, rsp_last_ff;
   logic [WORD_W-1:0] rsp_inst_addr_ff, rsp_next_fetch_ff;
   logic [CNT_W-1:0]  rsp_inst_count_ff;

   logic [CFG_W-1:0]  limit;
   logic [6:0]        uops_sum;
   logic [WORD_W-1:0] fall;
   logic [CNT_W-1:0]  br_dec;
   logic [LINE_W-1:0] build_line, look_line, rd_line;
   logic [AMEM_W-1:0] amem_idx;
   logic              out_free;

   assign limit    = (max_uops_ff > CFG_W'(LINE_UOPS)) ? CFG_W'(LINE_UOPS) : max_uops_ff;
   assign uops_sum = 7'(b_uops_ff) + 7'(q_uops_ff);
   assign fall     = q_addr_ff + WORD_W'(q_size_ff);
   assign br_dec   = b_br_ff - CNT_W'(1);
   assign build_line = line_of(b_tag_ff, way_ff);
   assign look_line  = line_of(q_addr_ff, way_ff);
   assign rd_line    = cmd.meta_rd_lookup ? look_line : build_line;
   assign amem_idx   = AMEM_W'(int'(pick_line_ff) * LINE_UOPS + int'(idx_ff));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      eff = rd_meta_ff;
      if (!rd_valid_ff) begin
         eff     = '0;
         eff.age = rd_way_ff;
      end
      age_meta     = eff;
      age_meta.age = (eff.age == '0) ? WAY_W'(WAYS - 1) : eff.age - WAY_W'(1);
      new_meta = '{tag: b_tag_ff, mask: b_mask_ff, taken: b_taken_ff, bcount: b_br_ff,
                   target: b_target_ff, fall: b_fall_ff, icount: b_insts_ff,
                   ends: b_ends_ff, age: pick_age_ff};
   end

   always_comb begin
      status.is_lookup   = (q_func_ff == FUNC_LOOKUP);
      status.rec_skip    = !q_head_ff || (q_uops_ff == '0);
      status.overflow    = (uops_sum > 7'(limit)) && (b_uops_ff != '0);
      status.too_big     = q_uops_ff > UOPS_W'(limit);
      status.br_close    = b_ends_ff && (b_br_ff == max_br_ff);
      status.tag_zero    = (b_tag_ff == '0);
      status.search_take = !rd_valid_ff || ((eff.tag == b_tag_ff) &&
                           (eff.mask == b_mask_ff) && (eff.taken == b_taken_ff));
      status.last_way    = (way_ff == WAY_W'(WAYS - 1));
      status.lookup_hit  = rd_valid_ff && (eff.tag == q_addr_ff) &&
                           ((q_pred_ff & eff.mask) == eff.taken);
      status.n_zero      = (hit_n_ff == '0);
      status.last_idx_wr = (CNT_W'(idx_ff) + CNT_W'(1)) == b_insts_ff;
      status.last_idx_rd = (CNT_W'(idx_ff) + CNT_W'(1)) == hit_n_ff;
      status.out_free    = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_uops_ff <= CFG_W'(16);
         max_br_ff   <= CFG_W'(3);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_LINE_UOPS:     max_uops_ff <= csr_wdata;
            CSR_MAX_LINE_BRANCHES: max_br_ff   <= csr_wdata;
            default:               max_br_ff   <= max_br_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_func_ff   <= req_func;
         q_addr_ff   <= req_fetch_addr;
         q_head_ff   <= req_is_head;
         q_uops_ff   <= req_inst_uops;
         q_size_ff   <= req_inst_size;
         q_branch_ff <= req_is_branch;
         q_next_ff   <= req_actual_next;
         q_target_ff <= req_branch_target;
         q_pred_ff   <= req_pred_bits;
      end
   end

   always_comb begin
      b_tag_in    = b_tag_ff;
      b_uops_in   = b_uops_ff;
      b_insts_in  = b_insts_ff;
      b_br_in     = b_br_ff;
      b_mask_in   = b_mask_ff;
      b_taken_in  = b_taken_ff;
      b_target_in = b_target_ff;
      b_fall_in   = b_fall_ff;
      b_ends_in   = b_ends_ff;
      if (cmd.clear_build) begin
         b_tag_in    = '0;
         b_uops_in   = '0;
         b_insts_in  = '0;
         b_br_in     = '0;
         b_mask_in   = '0;
         b_taken_in  = '0;
         b_target_in = '0;
         b_fall_in   = '0;
         b_ends_in   = 1'b0;
      end else if (cmd.adjust) begin
         if (b_ends_ff && (b_br_ff != '0)) begin
            b_br_in = br_dec;
            if (br_dec < CNT_W'(MASK_W)) begin
               b_mask_in[br_dec[BIT_W-1:0]]  = 1'b0;
               b_taken_in[br_dec[BIT_W-1:0]] = 1'b0;
            end
         end
      end else if (cmd.append) begin
         if (b_uops_ff == '0) begin
            b_tag_in = q_addr_ff;
         end
         b_insts_in  = b_insts_ff + CNT_W'(1);
         b_uops_in   = b_uops_ff + CNT_W'(q_uops_ff);
         b_ends_in   = q_branch_ff;
         b_target_in = q_branch_ff ? q_target_ff : '0;
         b_fall_in   = fall;
         if (q_branch_ff) begin
            if (b_br_ff < CNT_W'(MASK_W)) begin
               b_mask_in[b_br_ff[BIT_W-1:0]] = 1'b1;
               if (q_next_ff != fall) begin
                  b_taken_in[b_br_ff[BIT_W-1:0]] = 1'b1;
               end
            end
            b_br_in = b_br_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_tag_ff    <= '0;
         b_uops_ff   <= '0;
         b_insts_ff  <= '0;
         b_br_ff     <= '0;
         b_mask_ff   <= '0;
         b_taken_ff  <= '0;
         b_target_ff <= '0;
         b_fall_ff   <= '0;
         b_ends_ff   <= 1'b0;
      end else begin
         b_tag_ff    <= b_tag_in;
         b_uops_ff   <= b_uops_in;
         b_insts_ff  <= b_insts_in;
         b_br_ff     <= b_br_in;
         b_mask_ff   <= b_mask_in;
         b_taken_ff  <= b_taken_in;
         b_target_ff <= b_target_in;
         b_fall_ff   <= b_fall_in;
         b_ends_ff   <= b_ends_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && (b_insts_ff < CNT_W'(LINE_UOPS))) begin
         b_addrs_ff[b_insts_ff[SLOT_W-1:0]] <= q_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.meta_wr) begin
         valid_ff[pick_line_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.age_wr) begin
         meta_mem[build_line] <= age_meta;
      end else if (cmd.meta_wr) begin
         meta_mem[pick_line_ff] <= new_meta;
      end
      if (cmd.meta_rd_commit || cmd.meta_rd_lookup) begin
         rd_meta_ff  <= meta_mem[rd_line];
         rd_valid_ff <= valid_ff[rd_line];
         rd_way_ff   <= way_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.addr_wr) begin
         addr_mem[amem_idx] <= b_addrs_ff[idx_ff];
      end
      if (cmd.addr_rd) begin
         rd_addr_ff <= addr_mem[amem_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.way_clr) begin
         way_ff <= '0;
      end else if (cmd.way_inc) begin
         way_ff <= way_ff + WAY_W'(1);
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + SLOT_W'(1);
      end
      if (cmd.pick_set) begin
         pick_line_ff <= build_line;
         pick_age_ff  <= eff.age;
      end else if (cmd.age_wr && (eff.age == '0)) begin
         pick_line_ff <= build_line;
         pick_age_ff  <= WAY_W'(WAYS - 1);
      end else if (cmd.hit_latch) begin
         pick_line_ff <= look_line;
      end
      if (cmd.hit_latch) begin
         hit_n_ff  <= eff.icount;
         hit_nf_ff <= (eff.ends && (eff.bcount < CNT_W'(MASK_W)) &&
                       q_pred_ff[eff.bcount[BIT_W-1:0]]) ? eff.target : eff.fall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_miss || cmd.out_hit0 || cmd.out_stream) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_miss) begin
         rsp_hit_ff        <= 1'b0;
         rsp_inst_addr_ff  <= '0;
         rsp_inst_count_ff <= '0;
         rsp_next_fetch_ff <= '0;
         rsp_last_ff       <= 1'b1;
      end else if (cmd.out_hit0) begin
         rsp_hit_ff        <= 1'b1;
         rsp_inst_addr_ff  <= '0;
         rsp_inst_count_ff <= '0;
         rsp_next_fetch_ff <= hit_nf_ff;
         rsp_last_ff       <= 1'b1;
      end else if (cmd.out_stream) begin
         rsp_hit_ff        <= 1'b1;
         rsp_inst_addr_ff  <= rd_addr_ff;
         rsp_inst_count_ff <= hit_n_ff;
         rsp_next_fetch_ff <= hit_nf_ff;
         rsp_last_ff       <= status.last_idx_rd;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_inst_addr  = rsp_inst_addr_ff;
   assign rsp_inst_count = rsp_inst_count_ff;
   assign rsp_next_fetch = rsp_next_fetch_ff;
   assign rsp_last       = rsp_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_miss || cmd.out_hit0 || cmd.out_stream) |-> out_free)
      else $error("result register loaded while a word is still pending");

   a_line_tag_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.meta_wr |-> (b_tag_ff != '0))
      else $error("line written with a zero tag");

   a_build_fits: assert property (@(posedge clock) disable iff (reset)
      (b_uops_ff <= CNT_W'(LINE_UOPS)) && (b_insts_ff <= b_uops_ff))
      else $error("trace under construction exceeds line capacity");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import tcfl_pkg::*;

   typedef struct packed {
      logic              func;
      logic [WORD_W-1:0] addr;
      logic              head;
      logic [UOPS_W-1:0] uops;
      logic [SIZE_W-1:0] size;
      logic              br;
      logic [WORD_W-1:0] actual;
      logic [WORD_W-1:0] target;
      logic [MASK_W-1:0] pred;
   } fetch_word_type;

   typedef struct packed {
      logic              hit;
      logic [WORD_W-1:0] iaddr;
      logic [CNT_W-1:0]  icount;
      logic [WORD_W-1:0] nfetch;
      logic              last;
   } trace_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   fetch_word_type    req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_hit;
   logic [WORD_W-1:0] rsp_inst_addr;
   logic [CNT_W-1:0]  rsp_inst_count;
   logic [WORD_W-1:0] rsp_next_fetch;
   logic              rsp_last;
   logic              csr_we = 1'b0;
   logic [0:0]        csr_index = '0;
   logic [CFG_W-1:0]  csr_wdata = '0;

   always #6 clock = ~clock;

   trace_cache_fill_and_lookup_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_word.func), .req_fetch_addr(req_word.addr),
      .req_is_head(req_word.head), .req_inst_uops(req_word.uops),
      .req_inst_size(req_word.size), .req_is_branch(req_word.br),
      .req_actual_next(req_word.actual), .req_branch_target(req_word.target),
      .req_pred_bits(req_word.pred),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_inst_addr(rsp_inst_addr), .rsp_inst_count(rsp_inst_count),
      .rsp_next_fetch(rsp_next_fetch), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   localparam int LINES_N = SETS * WAYS;

   logic [4:0]        uop_limit, branch_limit;
   logic [31:0]       tc_tag [LINES_N];
   logic [15:0]       tc_mask [LINES_N], tc_taken [LINES_N];
   logic [4:0]        tc_bcount [LINES_N], tc_icount [LINES_N];
   logic [31:0]       tc_target [LINES_N], tc_fall [LINES_N];
   logic              tc_ends [LINES_N];
   logic [1:0]        tc_age [LINES_N];
   logic [31:0]       tc_addrs [LINES_N][LINE_UOPS];
   logic [31:0]       fu_tag, fu_target, fu_fall;
   logic [31:0]       fu_uops, fu_insts, fu_branches;
   logic [31:0]       fu_addrs [LINE_UOPS];
   logic [15:0]       fu_mask, fu_taken;
   logic              fu_ends;

   trace_word_type    expected_trace [$];
   int                errors = 0;
   int                words_sent = 0, lookups = 0, hits = 0, results = 0;
   bit                req_idle_on = 1'b1, rsp_idle_on = 1'b1;

   function automatic void clear_fill();
      fu_tag = 0; fu_uops = 0; fu_insts = 0; fu_branches = 0;
      fu_mask = 0; fu_taken = 0; fu_target = 0; fu_fall = 0; fu_ends = 0;
      foreach (fu_addrs[i]) fu_addrs[i] = 0;
   endfunction

   function automatic void reset_cache();
      uop_limit = 16;
      branch_limit = 3;
      for (int e = 0; e < LINES_N; e++) begin
         tc_tag[e] = 0; tc_mask[e] = 0; tc_taken[e] = 0; tc_bcount[e] = 0;
         tc_target[e] = 0; tc_fall[e] = 0; tc_icount[e] = 0; tc_ends[e] = 0;
         tc_age[e] = 2'(e % WAYS);
         for (int i = 0; i < LINE_UOPS; i++) tc_addrs[e][i] = 0;
      end
      clear_fill();
   endfunction

   function automatic void commit_fill();
      int base, pick;
      pick = -1;
      if (fu_ends && fu_branches > 0) begin
         fu_branches--;
         if (fu_branches < 16) begin
            fu_mask[fu_branches] = 1'b0;
            fu_taken[fu_branches] = 1'b0;
         end
      end
      if (fu_tag == 0) begin
         clear_fill();
         return;
      end
      base = (fu_tag % SETS) * WAYS;
      for (int w = 0; w < WAYS; w++) begin
         if (pick < 0 && ((tc_tag[base+w] == fu_tag && tc_mask[base+w] == fu_mask &&
             tc_taken[base+w] == fu_taken) || tc_tag[base+w] == 0))
            pick = base + w;
      end
      if (pick < 0) begin
         for (int w = 0; w < WAYS; w++) begin
            if (tc_age[base+w] == 0) begin
               tc_age[base+w] = 2'(WAYS - 1);
               pick = base + w;
            end else begin
               tc_age[base+w]--;
            end
         end
      end
      if (pick < 0) pick = base;
      tc_tag[pick] = fu_tag;
      tc_mask[pick] = fu_mask;
      tc_taken[pick] = fu_taken;
      tc_bcount[pick] = fu_branches[4:0];
      tc_target[pick] = fu_ends ? fu_target : 0;
      tc_fall[pick] = fu_fall;
      tc_icount[pick] = fu_insts[4:0];
      tc_ends[pick] = fu_ends;
      for (int i = 0; i < LINE_UOPS; i++) tc_addrs[pick][i] = fu_addrs[i];
      clear_fill();
   endfunction

   function automatic void predict_trace(fetch_word_type f);
      int base, pick, n;
      logic [31:0] limit, fall, nf;
      trace_word_type t;
      pick = -1;
      if (f.func == FUNC_RECORD) begin
         limit = (uop_limit > LINE_UOPS) ? LINE_UOPS : uop_limit;
         fall = f.addr + f.size;
         if (!f.head || f.uops == 0) return;
         if (fu_uops + f.uops > limit && fu_uops != 0) commit_fill();
         if (f.uops > limit) return;
         if (fu_uops == 0) fu_tag = f.addr;
         if (fu_insts < LINE_UOPS) fu_addrs[fu_insts] = f.addr;
         fu_insts++;
         fu_uops += f.uops;
         fu_ends = 0;
         fu_target = 0;
         fu_fall = fall;
         if (f.br) begin
            if (fu_branches < 16) begin
               fu_mask[fu_branches] = 1'b1;
               if (f.actual != fall) fu_taken[fu_branches] = 1'b1;
            end
            fu_branches++;
            fu_ends = 1;
            fu_target = f.target;
            if (fu_branches == branch_limit) commit_fill();
         end
         return;
      end
      lookups++;
      base = (f.addr % SETS) * WAYS;
      if (f.addr != 0) begin
         for (int w = 0; w < WAYS; w++) begin
            if (pick < 0 && tc_tag[base+w] == f.addr &&
                (f.pred & tc_mask[base+w]) == tc_taken[base+w])
               pick = base + w;
         end
      end
      if (pick < 0) begin
         t = '0;
         t.last = 1'b1;
         expected_trace.push_back(t);
         return;
      end
      hits++;
      nf = tc_fall[pick];
      if (tc_ends[pick] && tc_bcount[pick] < 16 && f.pred[tc_bcount[pick]]) nf = tc_target[pick];
      n = (tc_icount[pick] > LINE_UOPS) ? LINE_UOPS : tc_icount[pick];
      if (n == 0) begin
         t = '{hit: 1'b1, iaddr: '0, icount: '0, nfetch: nf, last: 1'b1};
         expected_trace.push_back(t);
         return;
      end
      for (int i = 0; i < n; i++) begin
         t = '{hit: 1'b1, iaddr: tc_addrs[pick][i], icount: n[4:0], nfetch: nf,
               last: (i + 1 == n)};
         expected_trace.push_back(t);
      end
   endfunction

   always @(posedge clock) begin
      trace_word_type exp_t;
      if (!reset && rsp_valid && !rsp_stall) begin
         results++;
         if (expected_trace.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            exp_t = expected_trace.pop_front();
            if (rsp_hit !== exp_t.hit) begin
               $error("hit: expected %0h actual %0h", exp_t.hit, rsp_hit); errors++;
            end
            if (rsp_inst_addr !== exp_t.iaddr) begin
               $error("inst_addr: expected %0h actual %0h", exp_t.iaddr, rsp_inst_addr);
               errors++;
            end
            if (rsp_inst_count !== exp_t.icount) begin
               $error("inst_count: expected %0h actual %0h", exp_t.icount, rsp_inst_count);
               errors++;
            end
            if (rsp_next_fetch !== exp_t.nfetch) begin
               $error("next_fetch: expected %0h actual %0h", exp_t.nfetch, rsp_next_fetch);
               errors++;
            end
            if (rsp_last !== exp_t.last) begin
               $error("last: expected %0h actual %0h", exp_t.last, rsp_last); errors++;
            end
         end
      end
   end

   int rsp_burst = 0;
   always @(posedge clock) begin
      if (rsp_burst > 0) begin
         rsp_burst <= rsp_burst - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_burst <= $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(fetch_word_type f);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_word <= f;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_trace(f);
      words_sent++;
   endtask

   task automatic drain_and_write(logic [0:0] idx, logic [4:0] value);
      req_valid <= 1'b0;
      while (expected_trace.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_LINE_UOPS) uop_limit = value;
      else branch_limit = value;
   endtask

   function automatic fetch_word_type rec_word(logic [31:0] a, int u, int s, bit b,
                                               bit tk, logic [31:0] tg);
      fetch_word_type f;
      f = '0;
      f.func = FUNC_RECORD;
      f.addr = a; f.head = 1'b1; f.uops = UOPS_W'(u); f.size = SIZE_W'(s); f.br = b;
      f.actual = tk ? tg : a + 32'(s);
      f.target = tg;
      return f;
   endfunction

   function automatic fetch_word_type look_word(logic [31:0] a, logic [15:0] p);
      fetch_word_type f;
      f = '0;
      f.func = FUNC_LOOKUP;
      f.addr = a; f.pred = p;
      f.head = 1'($urandom); f.uops = UOPS_W'($urandom); f.size = SIZE_W'($urandom);
      f.br = 1'($urandom);
      f.actual = $urandom; f.target = $urandom;
      return f;
   endfunction

   fetch_word_type directed_words [$];
   trace_word_type miss_word;

   task automatic random_phase(int count, logic [31:0] pool []);
      logic [31:0] a;
      fetch_word_type f;
      int k;
      k = 0;
      while (k < count) begin
         if ($urandom_range(0, 2) == 0) begin
            f = look_word(pool[$urandom_range(0, pool.size() - 1)], 16'($urandom));
            if ($urandom_range(0, 7) == 0) f.addr = $urandom;
            if ($urandom_range(0, 15) == 0) f.addr = 0;
            send_word(f);
            k++;
         end else begin
            a = pool[$urandom_range(0, pool.size() - 1)];
            for (int j = $urandom_range(1, 6); j > 0; j--) begin
               f = rec_word(a, $urandom_range(1, 6), $urandom_range(1, 15),
                            $urandom_range(0, 2) == 0, 1'($urandom), $urandom);
               case ($urandom_range(0, 19))
                  0: f.head = 1'b0;
                  1: f.uops = UOPS_W'($urandom_range(0, 63));
                  2: f.uops = 0;
                  3: f.actual = $urandom;
                  4: f.addr = $urandom;
                  default: ;
               endcase
               send_word(f);
               k++;
               a = f.br ? (f.actual) : a + f.size;
            end
         end
      end
   endtask

   initial begin
      logic [31:0] pool [];
      fetch_word_type f;
      reset_cache();
      miss_word = '0;
      miss_word.last = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_words.push_back(look_word(32'h0000_0040, 16'h0000));
      directed_words.push_back(look_word(32'h0000_0000, 16'hFFFF));
      directed_words.push_back(look_word(32'hFFFF_FFFF, 16'hFFFF));
      directed_words.push_back(rec_word(32'h0000_1000, 4, 15, 1'b1, 1'b1, 32'hFFFF_FFF0));
      directed_words.push_back(rec_word(32'hFFFF_FFF0, 4, 15, 1'b0, 1'b0, 0));
      f = rec_word(32'hFFFF_FFFF, 2, 1, 1'b0, 1'b0, 0);
      f.head = 1'b0;
      directed_words.push_back(f);
      directed_words.push_back(rec_word(32'hFFFF_FFFF, 0, 1, 1'b0, 1'b0, 0));
      directed_words.push_back(rec_word(32'hFFFF_FFFF, 8, 1, 1'b1, 1'b0, 32'h1234_5678));
      directed_words.push_back(rec_word(32'h0000_1000, 63, 4, 1'b0, 1'b0, 0));
      directed_words.push_back(look_word(32'h0000_1000, 16'h0001));
      directed_words.push_back(look_word(32'h0000_1000, 16'h0007));
      directed_words.push_back(look_word(32'h0000_1000, 16'h0000));
      directed_words.push_back(rec_word(32'h0000_0000, 3, 2, 1'b1, 1'b1, 32'h55));
      directed_words.push_back(rec_word(32'h0000_0002, 16, 2, 1'b0, 1'b0, 0));
      directed_words.push_back(rec_word(32'h0000_0004, 1, 2, 1'b0, 1'b0, 0));
      directed_words.push_back(look_word(32'h0000_0002, 16'h0000));
      directed_words.push_back(look_word(32'h0000_0000, 16'h0000));
      for (int i = 0; i < directed_words.size(); i++) begin
         send_word(directed_words[i]);
         if (i < 3 && expected_trace[$] != miss_word) begin
            $error("last: expected miss after reset");
            errors++;
         end
      end

      pool = new[8];
      foreach (pool[i]) pool[i] = ($urandom & 32'hFFFF_FF00) | ((i % 2) << 6) | 32'h10;
      random_phase(90, pool);
      drain_and_write(CSR_MAX_LINE_UOPS, 5'd31);
      drain_and_write(CSR_MAX_LINE_BRANCHES, 5'd16);
      random_phase(50, pool);
      drain_and_write(CSR_MAX_LINE_UOPS, 5'd1);
      drain_and_write(CSR_MAX_LINE_BRANCHES, 5'd1);
      random_phase(40, pool);
      drain_and_write(CSR_MAX_LINE_UOPS, 5'd0);
      drain_and_write(CSR_MAX_LINE_BRANCHES, 5'd0);
      random_phase(20, pool);
      drain_and_write(CSR_MAX_LINE_UOPS, 5'd10);
      drain_and_write(CSR_MAX_LINE_BRANCHES, 5'd31);
      random_phase(50, pool);
      drain_and_write(CSR_MAX_LINE_UOPS, 5'd16);
      drain_and_write(CSR_MAX_LINE_BRANCHES, 5'd3);
      random_phase(40, pool);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      random_phase(40, pool);
      req_valid <= 1'b0;

      while (expected_trace.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Sent %0d request words, %0d lookups with %0d hits, %0d result words.",
               words_sent, lookups, hits, results);
      if (errors == 0 && expected_trace.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
